/* rtl/core/tah_pkg.sv */
package tah_pkg;

  // Field widths fixed by the sample format and the register map.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CONV_W   = 17;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned ACT_W    = 15;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AVG_W    = 18;

  // Converted samples never go below -2^16, so adding this per entry makes the sum positive.
  localparam longint unsigned CONV_BIAS = 64'd65536;

  // Average limits in 1/256 percent.
  localparam logic signed [AVG_W-1:0] AVG_MAX = 18'sd25600;
  localparam logic signed [AVG_W-1:0] OUT_MIN = -18'sd32768;

  // Register reset values.
  localparam logic [ACT_W-1:0]    ACT_RESET    = 15'd1280;
  localparam logic [ACT_W-1:0]    BAND_RESET   = 15'd512;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd6516;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVATE = 2'd0,
    CFG_RELEASE  = 2'd1,
    CFG_OFFSET   = 2'd2
  } cfg_idx_t;

  // Channel payloads.
  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
  } tah_in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] throttle_level;
    logic                      gate_active;
  } tah_out_t;

endpackage

/* rtl/core/tah_stream_if.sv */
interface tah_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/tah_avg_div.sv */
module tah_avg_div
  import tah_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      adv,
  input  logic                                      sum_vld,
  input  logic signed [CONV_W+$clog2(WINDOW_LEN)-1:0] sum,
  output logic                                      avg_vld,
  output logic signed [AVG_W-1:0]                   avg
);

  localparam int unsigned UW = CONV_W + $clog2(WINDOW_LEN);
  localparam longint unsigned RECIP_L = (64'd1 << UW) / WINDOW_LEN;
  localparam logic [UW-1:0] RECIP    = UW'(RECIP_L);
  localparam logic [UW-1:0] WIN_U    = UW'(WINDOW_LEN);
  localparam logic [UW-1:0] BIAS_SUM = UW'(CONV_BIAS * WINDOW_LEN);
  localparam logic [CONV_W:0] Q_BIAS = (CONV_W+1)'(CONV_BIAS);

  logic            c_vld_r;
  logic [UW-1:0]   c_u_r;
  logic [2*UW-1:0] c_prod_r;
  logic            d_vld_r;
  logic signed [AVG_W-1:0] d_avg_r;

  logic [UW-1:0]     u_c;
  logic [UW-1:0]     q_hi;
  logic [CONV_W-1:0] q_est;
  logic [UW-1:0]     rem;
  logic [CONV_W-1:0] q_fix;
  logic signed [AVG_W-1:0] avg_nxt;

  // Bias the sum so it is non-negative, then multiply by the truncated reciprocal.
  assign u_c = UW'(sum) + BIAS_SUM;

  // The estimate is at most one low; one compare on the remainder fixes it.
  assign q_hi    = c_prod_r[2*UW-1 -: UW];
  assign q_est   = q_hi[CONV_W-1:0];
  assign rem     = c_u_r - (UW'(q_est) * WIN_U);
  assign q_fix   = q_est + CONV_W'(rem >= WIN_U);
  assign avg_nxt = AVG_W'(signed'({1'b0, q_fix}) - signed'(Q_BIAS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= sum_vld;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_u_r    <= u_c;
      c_prod_r <= u_c * RECIP;
      d_avg_r  <= avg_nxt;
    end
  end

  assign avg_vld = d_vld_r;
  assign avg     = d_avg_r;

endmodule

/* rtl/core/throttle_average_hysteresis_top.sv */
// Throttle averaging block with a hysteresis gate.
// in_req carries one 12-bit converter sample per request; out_res returns one
// result per request: the gated window average in 1/256 percent and the gate
// state. Both channels use valid/ready and move a request when both are high.
// The cfg_ port writes activate level, release band and zero offset; the user must
// write them only while the block is idle, which the block itself does not enforce;
// writes to an unused index are dropped. A new request is taken every cycle while
// out_res is not stalled; the sum update, the reciprocal multiply and its
// correction each sit in their own register stage, and the ring memory is read
// once and written once per cycle.
// When the receiver stalls, the whole pipeline holds and in_req.ready drops
// while a result waits; it rises again in the cycle the result is taken.
// Reset empties the pipeline, zeroes the running sum, the ring pointer and
// the gate, marks every ring entry as zero through per-entry valid bits and
// restores the register reset values. No clearing pass is needed.
module throttle_average_hysteresis_top
  import tah_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tah_stream_if.sink           in_req,
  tah_stream_if.source         out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = CONV_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

  // Configuration registers.
  logic [ACT_W-1:0]    act_r;
  logic [ACT_W-1:0]    band_r;
  logic [OFFSET_W-1:0] offset_r;

  // Ring storage.
  logic signed [CONV_W-1:0] ring_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]    ent_vld_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_nxt;

  // Input stage.
  logic                     a_vld_r;
  logic [SLOT_W-1:0]        a_slot_r;
  logic signed [CONV_W-1:0] a_conv_r;
  logic signed [CONV_W-1:0] rd_r;
  logic                     rd_ok_r;

  // Sum stage.
  logic                    b_vld_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // Output stage.
  logic     out_vld_r;
  tah_out_t out_r;
  logic     gate_r;
  logic     gate_nxt;

  logic adv;
  logic accept;
  logic [CONV_W-1:0]        scaled;
  logic signed [CONV_W-1:0] conv;
  logic signed [CONV_W-1:0] old_val;
  logic                     avg_vld;
  logic signed [AVG_W-1:0]  avg;
  logic signed [AVG_W-1:0]  avg_cap;
  logic signed [AVG_W-1:0]  act_ext;
  logic signed [AVG_W-1:0]  rel_ext;
  logic signed [LEVEL_W-1:0] level;

  // The pipeline moves as a whole whenever the output register can take data.
  assign adv          = !out_vld_r || out_res.ready;
  assign accept       = adv && in_req.valid;
  assign in_req.ready = adv;

  // Scale by 25/2 with shifts, then remove the calibration offset.
  assign scaled = ({5'd0, in_req.data.adc_sample} << 4)
                + ({5'd0, in_req.data.adc_sample} << 3)
                + {5'd0, in_req.data.adc_sample};
  assign conv = signed'({1'b0, scaled[CONV_W-1:1]}) - signed'({1'b0, offset_r});

  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= ACT_RESET;
      band_r   <= BAND_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVATE: act_r    <= cfg_wdata[ACT_W-1:0];
        CFG_RELEASE:  band_r   <= cfg_wdata[ACT_W-1:0];
        CFG_OFFSET:   offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring read at the accepting edge.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= ring_mem[slot_r];
    end
  end

  // Ring write as the request leaves the input stage.
  always_ff @(posedge clk) begin
    if (adv && a_vld_r) begin
      ring_mem[a_slot_r] <= a_conv_r;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_slot_r <= slot_r;
      a_conv_r <= conv;
      rd_ok_r  <= ent_vld_r[slot_r];
    end
  end

  // Entries never written since reset read as zero.
  assign old_val = rd_ok_r ? rd_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(a_conv_r);

  // Control state of the ring and sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      ent_vld_r <= '0;
      sum_r     <= '0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_req.valid;
      b_vld_r <= a_vld_r;
      if (accept) begin
        slot_r <= slot_nxt;
      end
      if (a_vld_r) begin
        ent_vld_r[a_slot_r] <= 1'b1;
        sum_r               <= sum_nxt;
      end
    end
  end

  tah_avg_div #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .sum_vld (b_vld_r),
    .sum     (sum_r),
    .avg_vld (avg_vld),
    .avg     (avg)
  );

  // Hysteresis decision on the average capped at 100 percent. The low
  // saturation cannot change the decision, so it is left out here.
  assign avg_cap  = (avg > AVG_MAX) ? AVG_MAX : avg;
  assign act_ext  = signed'({3'd0, act_r});
  assign rel_ext  = act_ext - signed'({3'd0, band_r});
  assign gate_nxt = (gate_r || (avg_cap > act_ext)) && !(avg_cap < rel_ext);

  // Clamp to 100 percent above and to the 16-bit range below.
  always_comb begin
    if (avg > AVG_MAX) begin
      level = LEVEL_W'(AVG_MAX);
    end else if (avg < OUT_MIN) begin
      level = LEVEL_W'(OUT_MIN);
    end else begin
      level = avg[LEVEL_W-1:0];
    end
  end

  // Output register and gate state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      gate_r    <= 1'b0;
    end else if (adv) begin
      out_vld_r <= avg_vld;
      if (avg_vld) begin
        gate_r <= gate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && avg_vld) begin
      out_r.throttle_level <= gate_nxt ? level : '0;
      out_r.gate_active    <= gate_nxt;
    end
  end

  assign out_res.valid = out_vld_r;
  assign out_res.data  = out_r;

endmodule
